// File: rtl/tfs_pkg.sv
// ============================================================================
// tfs_pkg : shared types and constants for the transfer fragment splitter
// Field widths, status and register codes, sequencer states, defaults.
// ============================================================================
`default_nettype none

package tfs_pkg;

    localparam int PAGE_BYTES_DEF     = 4096;
    localparam int IMMEDIATE_MAX_DEF  = 8;
    localparam int FRAGMENT_LIMIT_DEF = 131072;
    localparam int MAX_FRAGMENTS_DEF  = 64;

    localparam int REQ_W    = 24;
    localparam int IMM_W    = 8;
    localparam int STREAM_W = 16;
    localparam int TAG_W    = 32;
    localparam int STAT_W   = 3;
    localparam int FB_W     = 18;
    localparam int PE_W     = 6;
    localparam int FC_W     = 7;

    localparam int MPS_W    = 11;
    localparam int BURST_W  = 4;
    localparam int MULT_W   = 2;
    localparam int BM_W     = 7;
    localparam int MBP_W    = MPS_W + BM_W;

    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [REQ_W-1:0] BIG_REQ_BYTES = REQ_W'(1 << 23);
    localparam logic [PE_W-1:0]  PAGE_SLACK    = PE_W'(2);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_ABORTING    = 3'd1,
        STAT_UNSUPPORTED = 3'd2,
        STAT_NO_BUFFER   = 3'd3,
        STAT_TOO_MANY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_MAX_PACKET = 2'd0,
        REG_MAX_BURST  = 2'd1,
        REG_BURST_MULT = 2'd2,
        REG_ERRATA     = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CFG_BM,
        ST_CFG_MBP,
        ST_CFG_CHK,
        ST_CFG_DIV,
        ST_CFG_SUB,
        ST_CFG_LIM,
        ST_CHECK,
        ST_SETUP,
        ST_CALC,
        ST_EMIT,
        ST_ERR
    } state_t;

endpackage

`default_nettype wire

// File: rtl/transfer_fragment_splitter.sv
// ============================================================================
// transfer_fragment_splitter : split a transfer request into TD fragments
//
// Input channel (in_valid / in_stall) takes one request beat. The output
// channel (out_valid / out_stall) returns one beat per fragment, in order,
// or one error beat; the final beat of a request has last set.
// Steps: accept, then the check and setup steps, then a calc and an emit
// step per fragment, all through one shared subtract/compare unit;
// immediate data skips the setup step, and an error goes from the check
// step to the error beat. The page estimate uses one reciprocal multiplier,
// registered into the output beat.
// in_stall stays high from accept until the last beat is loaded into the
// output register, and while the fragment size is recomputed.
// An APB write starts the fragment-size recompute through the CFG_BM,
// CFG_MBP, CFG_CHK, CFG_DIV (bit-serial divide), CFG_SUB and CFG_LIM steps,
// input stalled from the access cycle on.
// Reset clears the state, out_valid and the configuration registers and sets the fragment size to the limit.
// A stalled output beat holds; the block waits in its emit or error step
// until the output register frees up.
// ============================================================================
`default_nettype none

module transfer_fragment_splitter
    import tfs_pkg::*;
#(
    parameter int PAGE_BYTES     = PAGE_BYTES_DEF,
    parameter int IMMEDIATE_MAX  = IMMEDIATE_MAX_DEF,
    parameter int FRAGMENT_LIMIT = FRAGMENT_LIMIT_DEF,
    parameter int MAX_FRAGMENTS  = MAX_FRAGMENTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [REQ_W-1:0]    req_bytes,
    input  wire logic                has_dma_buffer,
    input  wire logic [IMM_W-1:0]    immediate_size,
    input  wire logic [STREAM_W-1:0] stream_id,
    input  wire logic [TAG_W-1:0]    transfer_tag,
    input  wire logic                endpoint_aborting,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [REQ_W-1:0]         offset_bytes,
    output logic [FB_W-1:0]          fragment_bytes,
    output logic [REQ_W-1:0]         bytes_after,
    output logic                     irq_on_done,
    output logic                     multi_fragment,
    output logic                     is_immediate,
    output logic [PE_W-1:0]          page_estimate,
    output logic [STREAM_W-1:0]      stream_out,
    output logic [TAG_W-1:0]         tag_out,
    output logic [FC_W-1:0]          fragment_count,
    output logic                     last
);

    localparam int FL_W    = $clog2(FRAGMENT_LIMIT + 1);
    localparam int CNT_W   = $clog2(MAX_FRAGMENTS + 1);
    localparam int LIMIT_W = $clog2(FRAGMENT_LIMIT * MAX_FRAGMENTS + 1);
    localparam int DIV_W   = MBP_W + 1;
    localparam int BIT_W   = $clog2(FL_W);
    localparam int ALU_W0  = (LIMIT_W > REQ_W) ? LIMIT_W : REQ_W;
    localparam int ALU_W1  = (ALU_W0 > DIV_W) ? ALU_W0 : DIV_W;
    localparam int ALU_W   = (ALU_W1 > FL_W) ? ALU_W1 : FL_W;
    localparam int PROD_W  = 2 * FL_W + 1;

    localparam logic [FL_W-1:0]    LIM_V     = FL_W'(FRAGMENT_LIMIT);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(FRAGMENT_LIMIT * MAX_FRAGMENTS);
    localparam logic [IMM_W-1:0]   IMM_MAX_V = IMM_W'(IMMEDIATE_MAX);
    localparam logic [CNT_W-1:0]   MAXF_CNT  = CNT_W'(MAX_FRAGMENTS);

    localparam int          PG_K   = FL_W + $clog2(PAGE_BYTES);
    localparam logic [63:0] PG_ONE = 64'd1 << PG_K;
    localparam logic [63:0] PG_DIV = 64'(PAGE_BYTES);
    localparam logic [FL_W:0] PG_M = (FL_W + 1)'((PG_ONE + PG_DIV - 64'd1) / PG_DIV);

    state_t state_reg, state_next;

    logic [MPS_W-1:0]   mps_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic               errata_reg;
    logic [FL_W-1:0]    maxf_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [BM_W-1:0]    bm_reg;
    logic [MBP_W-1:0]   mbp_reg;
    logic [MBP_W-1:0]   rem_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               use_rem_reg;

    logic [REQ_W-1:0]    req_reg;
    logic                buf_reg;
    logic [IMM_W-1:0]    imm_reg;
    logic [STREAM_W-1:0] stream_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                abort_reg;
    status_t             err_reg;

    logic [REQ_W-1:0] left_reg;
    logic [FL_W-1:0]  per_reg;
    logic [REQ_W-1:0] done_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             multi_reg;
    logic             imm_flag_reg;
    logic [FL_W-1:0]  cur_reg;
    logic [REQ_W-1:0] after_reg;
    logic             final_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg;
    logic [REQ_W-1:0]    offset_reg;
    logic [FB_W-1:0]     frag_bytes_reg;
    logic [REQ_W-1:0]    after_out_reg;
    logic                irq_reg;
    logic                multi_out_reg;
    logic                imm_out_reg;
    logic [PE_W-1:0]     pages_reg;
    logic [STREAM_W-1:0] stream_out_reg;
    logic [TAG_W-1:0]    tag_out_reg;
    logic [FC_W-1:0]     count_reg;
    logic                last_reg;

    logic               cfg_wr;
    logic               in_acc;
    logic               out_free;
    logic               load_frag;
    logic               load_err;
    logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
    logic               alu_borrow, alu_zero;
    logic [DIV_W-1:0]   div_shift;
    logic               chk_imm;
    status_t            chk_status;
    logic               calc_final;
    logic [PROD_W-1:0]  pg_prod;
    logic [CNT_W-1:0]   idx_inc;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign div_shift  = {rem_reg, LIM_V[bit_reg]};
    assign chk_imm    = (imm_reg <= IMM_MAX_V);
    assign calc_final = alu_borrow || alu_zero;
    assign pg_prod    = PROD_W'(cur_reg) * PROD_W'(PG_M);
    assign idx_inc    = idx_reg + CNT_W'(1);

    always_comb
    begin
        if (abort_reg)
            chk_status = STAT_ABORTING;
        else if (errata_reg && (req_reg >= BIG_REQ_BYTES))
            chk_status = STAT_UNSUPPORTED;
        else if ((req_reg != '0) && !buf_reg)
            chk_status = STAT_NO_BUFFER;
        else if (!chk_imm && alu_borrow)
            chk_status = STAT_TOO_MANY;
        else
            chk_status = STAT_OK;
    end

    tfs_alu #(
        .W (ALU_W)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow),
        .zero   (alu_zero)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_acc) state_next = ST_CHECK;
            ST_CFG_BM:  state_next = ST_CFG_MBP;
            ST_CFG_MBP: state_next = ST_CFG_CHK;
            ST_CFG_CHK: state_next = ST_CFG_DIV;
            ST_CFG_DIV: if (bit_reg == '0) state_next = ST_CFG_SUB;
            ST_CFG_SUB: state_next = ST_CFG_LIM;
            ST_CFG_LIM: state_next = ST_IDLE;
            ST_CHECK:
            begin
                if (chk_status != STAT_OK)
                    state_next = ST_ERR;
                else if (chk_imm)
                    state_next = ST_CALC;
                else
                    state_next = ST_SETUP;
            end
            ST_SETUP:   state_next = ST_CALC;
            ST_CALC:    state_next = ST_EMIT;
            ST_EMIT:    if (out_free) state_next = final_reg ? ST_IDLE : ST_CALC;
            ST_ERR:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
        if (cfg_wr)
            state_next = ST_CFG_BM;
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE) || cfg_wr;
        load_frag = 1'b0;
        load_err  = 1'b0;
        alu_a     = '0;
        alu_b     = '0;
        unique case (state_reg)
            ST_CFG_CHK:
            begin
                alu_a = ALU_W'(mbp_reg);
                alu_b = ALU_W'(LIM_V);
            end
            ST_CFG_DIV:
            begin
                alu_a = ALU_W'(div_shift);
                alu_b = ALU_W'(mbp_reg);
            end
            ST_CFG_SUB:
            begin
                alu_a = ALU_W'(LIM_V);
                alu_b = ALU_W'(rem_reg);
            end
            ST_CHECK:
            begin
                alu_a = ALU_W'(limit_reg);
                alu_b = ALU_W'(req_reg);
            end
            ST_SETUP:
            begin
                alu_a = ALU_W'(maxf_reg);
                alu_b = ALU_W'(req_reg);
            end
            ST_CALC:
            begin
                alu_a = ALU_W'(left_reg);
                alu_b = ALU_W'(per_reg);
            end
            ST_EMIT: load_frag = out_free;
            ST_ERR:  load_err  = out_free;
            default:
            begin
                load_frag = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_frag || load_err)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mps_reg       <= '0;
            burst_reg     <= '0;
            mult_reg      <= '0;
            errata_reg    <= 1'b0;
            maxf_reg      <= LIM_V;
            limit_reg     <= LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unique case (cfg_reg_t'(paddr[3:2]))
                    REG_MAX_PACKET: mps_reg    <= pwdata[MPS_W-1:0];
                    REG_MAX_BURST:  burst_reg  <= pwdata[BURST_W-1:0];
                    REG_BURST_MULT: mult_reg   <= pwdata[MULT_W-1:0];
                    REG_ERRATA:     errata_reg <= pwdata[0];
                    default:        errata_reg <= errata_reg;
                endcase
            end
            if (state_reg == ST_CFG_SUB)
                maxf_reg <= use_rem_reg ? alu_diff[FL_W-1:0] : LIM_V;
            if (state_reg == ST_CFG_LIM)
                limit_reg <= LIMIT_W'(maxf_reg) * LIMIT_W'(MAX_FRAGMENTS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg    <= req_bytes;
            buf_reg    <= has_dma_buffer;
            imm_reg    <= immediate_size;
            stream_reg <= stream_id;
            tag_reg    <= transfer_tag;
            abort_reg  <= endpoint_aborting;
        end

        case (state_reg)
            ST_CFG_BM:
                bm_reg <= (BM_W'(burst_reg) + BM_W'(1)) * (BM_W'(mult_reg) + BM_W'(1));
            ST_CFG_MBP:
            begin
                mbp_reg <= MBP_W'(mps_reg) * MBP_W'(bm_reg);
                rem_reg <= '0;
                bit_reg <= BIT_W'(FL_W - 1);
            end
            ST_CFG_CHK:
                use_rem_reg <= alu_borrow && (mbp_reg != '0);
            ST_CFG_DIV:
            begin
                rem_reg <= alu_borrow ? div_shift[MBP_W-1:0] : alu_diff[MBP_W-1:0];
                bit_reg <= bit_reg - BIT_W'(1);
            end
            ST_CHECK:
            begin
                err_reg      <= chk_status;
                done_reg     <= '0;
                idx_reg      <= '0;
                multi_reg    <= 1'b0;
                imm_flag_reg <= chk_imm;
                left_reg     <= REQ_W'(imm_reg);
                per_reg      <= FL_W'(imm_reg);
            end
            ST_SETUP:
            begin
                left_reg  <= req_reg;
                multi_reg <= alu_borrow;
                per_reg   <= alu_borrow ? maxf_reg : FL_W'(req_reg);
            end
            ST_CALC:
            begin
                final_reg <= calc_final;
                cur_reg   <= calc_final ? FL_W'(left_reg) : per_reg;
                after_reg <= calc_final ? '0 : alu_diff[REQ_W-1:0];
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    left_reg <= after_reg;
                    done_reg <= done_reg + REQ_W'(cur_reg);
                    idx_reg  <= idx_inc;
                end
            end
            default:
            begin
                bit_reg <= bit_reg;
            end
        endcase

        if (load_frag)
        begin
            status_reg     <= STAT_OK;
            offset_reg     <= done_reg;
            frag_bytes_reg <= FB_W'(cur_reg);
            after_out_reg  <= after_reg;
            irq_reg        <= 1'b1;
            multi_out_reg  <= multi_reg;
            imm_out_reg    <= imm_flag_reg;
            pages_reg      <= PE_W'(pg_prod >> PG_K) + PAGE_SLACK;
            stream_out_reg <= stream_reg;
            tag_out_reg    <= tag_reg;
            count_reg      <= final_reg ? FC_W'(idx_inc) : '0;
            last_reg       <= final_reg;
        end
        else if (load_err)
        begin
            status_reg     <= err_reg;
            offset_reg     <= '0;
            frag_bytes_reg <= '0;
            after_out_reg  <= '0;
            irq_reg        <= 1'b0;
            multi_out_reg  <= 1'b0;
            imm_out_reg    <= 1'b0;
            pages_reg      <= '0;
            stream_out_reg <= '0;
            tag_out_reg    <= '0;
            count_reg      <= '0;
            last_reg       <= 1'b1;
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_MAX_PACKET: prdata = APB_DW'(mps_reg);
            REG_MAX_BURST:  prdata = APB_DW'(burst_reg);
            REG_BURST_MULT: prdata = APB_DW'(mult_reg);
            REG_ERRATA:     prdata = APB_DW'(errata_reg);
            default:        prdata = '0;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign offset_bytes   = offset_reg;
    assign fragment_bytes = frag_bytes_reg;
    assign bytes_after    = after_out_reg;
    assign irq_on_done    = irq_reg;
    assign multi_fragment = multi_out_reg;
    assign is_immediate   = imm_out_reg;
    assign page_estimate  = pages_reg;
    assign stream_out     = stream_out_reg;
    assign tag_out        = tag_out_reg;
    assign fragment_count = count_reg;
    assign last           = last_reg;

`ifndef SYNTH
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STAT_OK)) |-> last_reg)
        else $error("error beat without last");

    a_maxf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (maxf_reg != '0) && (maxf_reg <= LIM_V))
        else $error("fragment size out of range");

    a_last_frag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg && (status_reg == STAT_OK))
            |-> ((count_reg != '0) && (after_out_reg == '0)))
        else $error("final fragment with bad count or remainder");

    a_mid_frag: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !final_reg) |-> (after_reg != '0))
        else $error("non-final fragment leaves no bytes");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg < MAXF_CNT))
        else $error("fragment index beyond limit");
`endif

endmodule

`default_nettype wire

// File: rtl/tfs_alu.sv
// ============================================================================
// tfs_alu : shared subtract and compare unit
// Unsigned difference of two operands with borrow and zero flags.
// ============================================================================
`default_nettype none

module tfs_alu #(
    parameter int W = 25
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] diff,
    output logic              borrow,
    output logic              zero
);

    logic [W:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[W-1:0];
    assign borrow = wide[W];
    assign zero   = (wide[W-1:0] == '0);

endmodule

`default_nettype wire
